/* src/lav_pkg.sv */
// ----------------------------------------------------------------------------
// lav_pkg: shared types and constants of the look-at view matrix core
// Holds the status struct that leaves each normalizer and the fixed widths
// and saturation limits of the position words.
// ----------------------------------------------------------------------------
package lav_pkg;

  // Width of every position and matrix word on the ports.
  localparam int unsigned XW = 32;

  // Saturation limits of a translation word.
  localparam logic [XW-1:0] SAT_POS = 32'h7fff_ffff;
  localparam logic [XW-1:0] SAT_NEG = 32'h8000_0000;

  // Status of a request leaving a normalizer stage.
  typedef struct packed {
    logic valid;  // the stage holds a request
    logic ok;     // the input vector was not zero
  } nrm_st_t;

endpackage

/* src/lav_if.sv */
// ----------------------------------------------------------------------------
// lav_in_if / lav_out_if: request and result channels
// Valid/ready channels that carry the camera request and the view matrix.
// ----------------------------------------------------------------------------
interface lav_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] eye_x;
  logic signed [31:0] eye_y;
  logic signed [31:0] eye_z;
  logic signed [31:0] aim_x;
  logic signed [31:0] aim_y;
  logic signed [31:0] aim_z;

  modport source (output valid, eye_x, eye_y, eye_z, aim_x, aim_y, aim_z, input ready);
  modport sink (input valid, eye_x, eye_y, eye_z, aim_x, aim_y, aim_z, output ready);
endinterface

interface lav_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] m00;
  logic signed [31:0] m01;
  logic signed [31:0] m02;
  logic signed [31:0] m10;
  logic signed [31:0] m11;
  logic signed [31:0] m12;
  logic signed [31:0] m20;
  logic signed [31:0] m21;
  logic signed [31:0] m22;
  logic signed [31:0] tr_x;
  logic signed [31:0] tr_y;
  logic signed [31:0] tr_z;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  tr_x, tr_y, tr_z, input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                tr_x, tr_y, tr_z, output ready);
endinterface

/* src/lav_norm.sv */
// ----------------------------------------------------------------------------
// lav_norm: pipelined 3-vector normalizer
// Scales the magnitudes by a power of two, takes the integer square root of
// the sum of squares one result bit per stage and divides each component by
// the length one quotient bit per stage. A side word travels with each request.
// ----------------------------------------------------------------------------
module lav_norm #(
  parameter int unsigned VW = 33,
  parameter int unsigned DF = 30,
  parameter int unsigned SW = 96
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [VW-1:0] vec_i [3],
  input  logic [SW-1:0]        side_i,
  output lav_pkg::nrm_st_t     st_o,
  output logic signed [DF+1:0] unit_o [3],
  output logic [SW-1:0]        side_o
);

  localparam int unsigned PW  = $clog2(VW);
  localparam int unsigned FW  = DF + 2;
  localparam int unsigned QB  = DF + 1;
  localparam int unsigned NW  = DF + 32;
  localparam int unsigned SQ  = 32;
  localparam int unsigned MW  = 31;
  localparam int unsigned KW  = SW + 4;
  localparam int unsigned CW  = KW + 3 * MW;
  localparam logic [PW-1:0] TOP = PW'(MW - 1);

  // Stage 1: magnitudes, signs and the OR of all magnitudes.
  logic              v1_q;
  logic [VW-1:0]     mag1_q [3];
  logic [VW-1:0]     mag1_d [3];
  logic [2:0]        sgn1_q;
  logic [VW-1:0]     or1_q;
  logic [SW-1:0]     side1_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag1_d[i] = vec_i[i][VW-1] ? VW'(-vec_i[i]) : VW'(vec_i[i]);
    end
  end

  // Stage 2: position of the leading one of the largest magnitude.
  logic              v2_q;
  logic [VW-1:0]     mag2_q [3];
  logic [2:0]        sgn2_q;
  logic [PW-1:0]     pos2_q;
  logic [PW-1:0]     pos2_d;
  logic              nz2_q;
  logic [SW-1:0]     side2_q;

  always_comb begin
    pos2_d = '0;
    for (int i = 0; i < VW; i++) begin
      if (or1_q[i]) pos2_d = PW'(i);
    end
  end

  // Stage 3: shift so that the largest magnitude lies in [2^30, 2^31).
  logic              v3_q;
  logic [MW-1:0]     m3_q [3];
  logic [MW-1:0]     m3_d [3];
  logic [2:0]        sgn3_q;
  logic              nz3_q;
  logic [SW-1:0]     side3_q;

  always_comb begin
    logic [VW-1:0] sh;
    for (int i = 0; i < 3; i++) begin
      if (pos2_q > TOP) begin
        sh = mag2_q[i] >> (pos2_q - TOP);
      end else begin
        sh = mag2_q[i] << (TOP - pos2_q);
      end
      m3_d[i] = sh[MW-1:0];
    end
  end

  // Stage 4: squares of the scaled magnitudes.
  logic              v4_q;
  logic [2*MW-1:0]   sq4_q [3];
  logic [2*MW-1:0]   sq4_d [3];
  logic [MW-1:0]     m4_q [3];
  logic [2:0]        sgn4_q;
  logic              nz4_q;
  logic [SW-1:0]     side4_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq4_d[i] = m3_q[i] * m3_q[i];
    end
  end

  // Square root: the sum enters at index 0, one result bit per stage.
  logic              sq_v_q [SQ+1];
  logic              sq_v_d [SQ+1];
  logic [63:0]       sq_n_q [SQ+1];
  logic [63:0]       sq_n_d [SQ+1];
  logic [63:0]       sq_r_q [SQ+1];
  logic [63:0]       sq_r_d [SQ+1];
  logic [CW-1:0]     sq_c_q [SQ+1];
  logic [CW-1:0]     sq_c_d [SQ+1];

  always_comb begin
    logic [63:0] b;
    logic [63:0] t;
    sq_v_d[0] = v4_q;
    sq_n_d[0] = 64'(sq4_q[0]) + 64'(sq4_q[1]) + 64'(sq4_q[2]);
    sq_r_d[0] = '0;
    sq_c_d[0] = {m4_q[0], m4_q[1], m4_q[2], sgn4_q, nz4_q, side4_q};
    for (int k = 0; k < SQ; k++) begin
      b = 64'd1 << (62 - 2 * k);
      t = sq_r_q[k] + b;
      sq_v_d[k+1] = sq_v_q[k];
      sq_c_d[k+1] = sq_c_q[k];
      if (sq_n_q[k] >= t) begin
        sq_n_d[k+1] = sq_n_q[k] - t;
        sq_r_d[k+1] = (sq_r_q[k] >> 1) + b;
      end else begin
        sq_n_d[k+1] = sq_n_q[k];
        sq_r_d[k+1] = sq_r_q[k] >> 1;
      end
    end
  end

  // Division: the rounded numerators enter at index 0, one quotient bit per stage.
  logic              dv_v_q   [QB+1];
  logic              dv_v_d   [QB+1];
  logic [31:0]       dv_len_q [QB+1];
  logic [31:0]       dv_len_d [QB+1];
  logic [NW-1:0]     dv_num_q [QB+1][3];
  logic [NW-1:0]     dv_num_d [QB+1][3];
  logic [31:0]       dv_rem_q [QB+1][3];
  logic [31:0]       dv_rem_d [QB+1][3];
  logic [QB-1:0]     dv_quo_q [QB+1][3];
  logic [QB-1:0]     dv_quo_d [QB+1][3];
  logic [KW-1:0]     dv_c_q   [QB+1];
  logic [KW-1:0]     dv_c_d   [QB+1];

  always_comb begin
    logic [CW-1:0] c;
    logic [MW-1:0] m;
    logic [31:0]   len;
    logic [NW-1:0] num;
    logic [32:0]   tt;
    logic          qb;
    c   = sq_c_q[SQ];
    len = sq_r_q[SQ][31:0];
    dv_v_d[0]   = sq_v_q[SQ];
    dv_len_d[0] = len;
    dv_c_d[0]   = c[KW-1:0];
    for (int i = 0; i < 3; i++) begin
      m   = c[CW-1-i*MW -: MW];
      num = (NW'(m) << DF) + NW'(len >> 1);
      dv_num_d[0][i] = num;
      dv_rem_d[0][i] = 32'(num[NW-1:QB]);
      dv_quo_d[0][i] = '0;
    end
    for (int j = 0; j < QB; j++) begin
      dv_v_d[j+1]   = dv_v_q[j];
      dv_len_d[j+1] = dv_len_q[j];
      dv_c_d[j+1]   = dv_c_q[j];
      for (int i = 0; i < 3; i++) begin
        tt = {dv_rem_q[j][i], dv_num_q[j][i][QB-1-j]};
        qb = (tt >= {1'b0, dv_len_q[j]});
        if (qb) begin
          tt = tt - {1'b0, dv_len_q[j]};
        end
        dv_num_d[j+1][i] = dv_num_q[j][i];
        dv_rem_d[j+1][i] = tt[31:0];
        dv_quo_d[j+1][i] = {dv_quo_q[j][i][QB-2:0], qb};
      end
    end
  end

  // Output stage: restore the signs.
  logic              ov_q;
  logic              ook_q;
  logic signed [FW-1:0] unit_q [3];
  logic signed [FW-1:0] unit_d [3];
  logic [SW-1:0]     oside_q;
  logic [KW-1:0]     kfin;

  always_comb begin
    logic signed [FW-1:0] q;
    kfin = dv_c_q[QB];
    for (int i = 0; i < 3; i++) begin
      q = $signed(FW'(dv_quo_q[QB][i]));
      unit_d[i] = kfin[SW+3-i] ? -q : q;
    end
  end

  // Valid bits, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      sq_v_q <= '{default: 1'b0};
      dv_v_q <= '{default: 1'b0};
      ov_q   <= 1'b0;
    end else if (en_i) begin
      v1_q   <= valid_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      sq_v_q <= sq_v_d;
      dv_v_q <= dv_v_d;
      ov_q   <= dv_v_q[QB];
    end
  end

  // Data registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag1_q   <= mag1_d;
      sgn1_q   <= {vec_i[0][VW-1], vec_i[1][VW-1], vec_i[2][VW-1]};
      or1_q    <= mag1_d[0] | mag1_d[1] | mag1_d[2];
      side1_q  <= side_i;
      mag2_q   <= mag1_q;
      sgn2_q   <= sgn1_q;
      pos2_q   <= pos2_d;
      nz2_q    <= |or1_q;
      side2_q  <= side1_q;
      m3_q     <= m3_d;
      sgn3_q   <= sgn2_q;
      nz3_q    <= nz2_q;
      side3_q  <= side2_q;
      sq4_q    <= sq4_d;
      m4_q     <= m3_q;
      sgn4_q   <= sgn3_q;
      nz4_q    <= nz3_q;
      side4_q  <= side3_q;
      sq_n_q   <= sq_n_d;
      sq_r_q   <= sq_r_d;
      sq_c_q   <= sq_c_d;
      dv_len_q <= dv_len_d;
      dv_num_q <= dv_num_d;
      dv_rem_q <= dv_rem_d;
      dv_quo_q <= dv_quo_d;
      dv_c_q   <= dv_c_d;
      unit_q   <= unit_d;
      ook_q    <= kfin[SW];
      oside_q  <= kfin[SW-1:0];
    end
  end

  assign st_o.valid = ov_q;
  assign st_o.ok    = ook_q;
  assign unit_o     = unit_q;
  assign side_o     = oside_q;

endmodule

/* src/look_at_view_matrix_core.sv */
// Throughput: one request per cycle while no result waits untaken; the square
// root and divider stages of the three normalizers resolve one bit per stage,
// which sets the depth. A stalled result holds the whole pipeline. Reset
// clears all valid bits.
// ----------------------------------------------------------------------------
// look_at_view_matrix_core: camera view matrix from eye and target
// Builds forward, right and up unit vectors with three pipelined normalizers
// and forms the rotation rows and saturated translations.
// ----------------------------------------------------------------------------
module look_at_view_matrix_core #(
  parameter int unsigned DIR_FRAC_BITS = 30
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lav_in_if.sink    req_i,
  lav_out_if.source res_o
);

  localparam int unsigned XW  = lav_pkg::XW;
  localparam int unsigned DF  = DIR_FRAC_BITS;
  localparam int unsigned FW  = DF + 2;
  localparam int unsigned EW  = 3 * XW;
  localparam int unsigned PXW = 2 * FW;
  localparam int unsigned TW  = 2 * FW + 1;
  localparam int unsigned S2W = EW + 3 * FW + 1;
  localparam int unsigned S3W = EW + 6 * FW;
  localparam int unsigned PRW = FW + XW;
  localparam int unsigned DW  = FW + XW + 2;
  localparam int unsigned MMW = DW - DF;
  localparam logic signed [FW-1:0] ONE = FW'(1) << DF;

  logic en;

  // Global advance: the pipeline moves unless a result waits untaken.
  logic out_v_q;
  assign en          = !out_v_q || res_o.ready;
  assign req_i.ready = en;

  // T0: direction from eye to target.
  logic                 t0_v_q;
  logic signed [XW-1:0] t0_eye_q [3];
  logic signed [XW:0]   t0_d_q [3];

  // First normalizer: forward.
  lav_pkg::nrm_st_t     n1_st;
  logic signed [FW-1:0] n1_u [3];
  logic [EW-1:0]        n1_side;

  lav_norm #(.VW(XW + 1), .DF(DF), .SW(EW)) u_norm_fwd (
    .clk_i, .rst_ni, .en_i(en), .valid_i(t0_v_q), .vec_i(t0_d_q),
    .side_i({t0_eye_q[0], t0_eye_q[1], t0_eye_q[2]}),
    .st_o(n1_st), .unit_o(n1_u), .side_o(n1_side)
  );

  // T1: forward with its fallback for a zero direction.
  logic                 t1_v_q;
  logic signed [FW-1:0] t1_f_q [3];
  logic signed [FW-1:0] t1_f_d [3];
  logic [EW-1:0]        t1_eye_q;

  always_comb begin
    if (n1_st.ok) begin
      t1_f_d = n1_u;
    end else begin
      t1_f_d[0] = '0;
      t1_f_d[1] = '0;
      t1_f_d[2] = -ONE;
    end
  end

  // T2: raw right vector (|fz|, 0, -fx * sign(fz)).
  logic                 t2_v_q;
  logic signed [FW-1:0] t2_t_q [3];
  logic signed [FW-1:0] t2_t_d [3];
  logic signed [FW-1:0] t2_f_q [3];
  logic                 t2_fz_q;
  logic [EW-1:0]        t2_eye_q;

  always_comb begin
    t2_t_d[0] = t1_f_q[2][FW-1] ? -t1_f_q[2] : t1_f_q[2];
    t2_t_d[1] = '0;
    t2_t_d[2] = t1_f_q[2][FW-1] ? t1_f_q[0] : -t1_f_q[0];
  end

  // Second normalizer: right.
  lav_pkg::nrm_st_t     n2_st;
  logic signed [FW-1:0] n2_u [3];
  logic [S2W-1:0]       n2_side;

  lav_norm #(.VW(FW), .DF(DF), .SW(S2W)) u_norm_right (
    .clk_i, .rst_ni, .en_i(en), .valid_i(t2_v_q), .vec_i(t2_t_q),
    .side_i({t2_eye_q, t2_f_q[0], t2_f_q[1], t2_f_q[2], t2_fz_q}),
    .st_o(n2_st), .unit_o(n2_u), .side_o(n2_side)
  );

  // T3: right with its fallback when forward z is zero.
  logic                 t3_v_q;
  logic signed [FW-1:0] t3_r_q [3];
  logic signed [FW-1:0] t3_r_d [3];
  logic signed [FW-1:0] t3_f_q [3];
  logic [EW-1:0]        t3_eye_q;

  always_comb begin
    if (n2_side[0] || !n2_st.ok) begin
      t3_r_d[0] = ONE;
      t3_r_d[1] = '0;
      t3_r_d[2] = '0;
    end else begin
      t3_r_d = n2_u;
    end
  end

  // T4: partial products of the cross product right x forward.
  logic                  t4_v_q;
  logic signed [PXW-1:0] t4_p_q [6];
  logic signed [PXW-1:0] t4_p_d [6];
  logic signed [FW-1:0]  t4_r_q [3];
  logic signed [FW-1:0]  t4_f_q [3];
  logic [EW-1:0]         t4_eye_q;

  always_comb begin
    t4_p_d[0] = t3_r_q[1] * t3_f_q[2];
    t4_p_d[1] = t3_r_q[2] * t3_f_q[1];
    t4_p_d[2] = t3_r_q[2] * t3_f_q[0];
    t4_p_d[3] = t3_r_q[0] * t3_f_q[2];
    t4_p_d[4] = t3_r_q[0] * t3_f_q[1];
    t4_p_d[5] = t3_r_q[1] * t3_f_q[0];
  end

  // T5: cross product differences.
  logic                 t5_v_q;
  logic signed [TW-1:0] t5_x_q [3];
  logic signed [TW-1:0] t5_x_d [3];
  logic signed [FW-1:0] t5_r_q [3];
  logic signed [FW-1:0] t5_f_q [3];
  logic [EW-1:0]        t5_eye_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t5_x_d[i] = TW'(t4_p_q[2*i]) - TW'(t4_p_q[2*i+1]);
    end
  end

  // Third normalizer: up.
  lav_pkg::nrm_st_t     n3_st;
  logic signed [FW-1:0] n3_u [3];
  logic [S3W-1:0]       n3_side;

  lav_norm #(.VW(TW), .DF(DF), .SW(S3W)) u_norm_up (
    .clk_i, .rst_ni, .en_i(en), .valid_i(t5_v_q), .vec_i(t5_x_q),
    .side_i({t5_eye_q, t5_r_q[0], t5_r_q[1], t5_r_q[2],
             t5_f_q[0], t5_f_q[1], t5_f_q[2]}),
    .st_o(n3_st), .unit_o(n3_u), .side_o(n3_side)
  );

  // T6: the three rotation rows: right, up and negated forward.
  logic                 t6_v_q;
  logic signed [FW-1:0] t6_row_q [9];
  logic signed [FW-1:0] t6_row_d [9];
  logic signed [XW-1:0] t6_eye_q [3];
  logic signed [XW-1:0] t6_eye_d [3];

  always_comb begin
    logic signed [FW-1:0] fv;
    for (int i = 0; i < 3; i++) begin
      t6_row_d[i]   = n3_side[6*FW-1-i*FW -: FW];
      fv            = n3_side[3*FW-1-i*FW -: FW];
      t6_row_d[6+i] = -fv;
      t6_eye_d[i]   = n3_side[S3W-1-i*XW -: XW];
    end
    if (n3_st.ok) begin
      t6_row_d[3] = n3_u[0];
      t6_row_d[4] = n3_u[1];
      t6_row_d[5] = n3_u[2];
    end else begin
      t6_row_d[3] = '0;
      t6_row_d[4] = ONE;
      t6_row_d[5] = '0;
    end
  end

  // T7: row times eye products.
  logic                  t7_v_q;
  logic signed [PRW-1:0] t7_p_q [9];
  logic signed [PRW-1:0] t7_p_d [9];
  logic signed [FW-1:0]  t7_row_q [9];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        t7_p_d[i*3+j] = t6_row_q[i*3+j] * t6_eye_q[j];
      end
    end
  end

  // T8: dot products.
  logic                 t8_v_q;
  logic signed [DW-1:0] t8_dot_q [3];
  logic signed [DW-1:0] t8_dot_d [3];
  logic signed [FW-1:0] t8_row_q [9];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t8_dot_d[i] = DW'(t7_p_q[3*i]) + DW'(t7_p_q[3*i+1]) + DW'(t7_p_q[3*i+2]);
    end
  end

  // T9: dot product magnitudes and signs.
  logic                 t9_v_q;
  logic [DW-1:0]        t9_mag_q [3];
  logic [DW-1:0]        t9_mag_d [3];
  logic [2:0]           t9_neg_q;
  logic signed [FW-1:0] t9_row_q [9];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t9_mag_d[i] = t8_dot_q[i][DW-1] ? DW'(-t8_dot_q[i]) : DW'(t8_dot_q[i]);
    end
  end

  // Output register: rounded, negated and saturated translations.
  logic signed [XW-1:0] out_m_q [9];
  logic signed [XW-1:0] out_m_d [9];
  logic [XW-1:0]        out_tr_q [3];
  logic [XW-1:0]        out_tr_d [3];

  always_comb begin
    logic [DW-1:0]  sum;
    logic [MMW-1:0] mm;
    for (int k = 0; k < 9; k++) begin
      out_m_d[k] = XW'(t9_row_q[k]);
    end
    for (int i = 0; i < 3; i++) begin
      sum = t9_mag_q[i] + (DW'(1) << (DF - 1));
      mm  = sum[DW-1:DF];
      if (t9_neg_q[i]) begin
        out_tr_d[i] = (mm > MMW'(lav_pkg::SAT_POS)) ? lav_pkg::SAT_POS : mm[XW-1:0];
      end else begin
        out_tr_d[i] = (mm > MMW'(lav_pkg::SAT_NEG)) ? lav_pkg::SAT_NEG : XW'(-mm);
      end
    end
  end

  // Valid bits, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t0_v_q  <= 1'b0;
      t1_v_q  <= 1'b0;
      t2_v_q  <= 1'b0;
      t3_v_q  <= 1'b0;
      t4_v_q  <= 1'b0;
      t5_v_q  <= 1'b0;
      t6_v_q  <= 1'b0;
      t7_v_q  <= 1'b0;
      t8_v_q  <= 1'b0;
      t9_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      t0_v_q  <= req_i.valid;
      t1_v_q  <= n1_st.valid;
      t2_v_q  <= t1_v_q;
      t3_v_q  <= n2_st.valid;
      t4_v_q  <= t3_v_q;
      t5_v_q  <= t4_v_q;
      t6_v_q  <= n3_st.valid;
      t7_v_q  <= t6_v_q;
      t8_v_q  <= t7_v_q;
      t9_v_q  <= t8_v_q;
      out_v_q <= t9_v_q;
    end
  end

  // Data registers.
  always_ff @(posedge clk_i) begin
    if (en) begin
      t0_eye_q[0] <= req_i.eye_x;
      t0_eye_q[1] <= req_i.eye_y;
      t0_eye_q[2] <= req_i.eye_z;
      t0_d_q[0]   <= (XW+1)'(req_i.aim_x) - (XW+1)'(req_i.eye_x);
      t0_d_q[1]   <= (XW+1)'(req_i.aim_y) - (XW+1)'(req_i.eye_y);
      t0_d_q[2]   <= (XW+1)'(req_i.aim_z) - (XW+1)'(req_i.eye_z);
      t1_f_q      <= t1_f_d;
      t1_eye_q    <= n1_side;
      t2_t_q      <= t2_t_d;
      t2_f_q      <= t1_f_q;
      t2_fz_q     <= (t1_f_q[2] == '0);
      t2_eye_q    <= t1_eye_q;
      t3_r_q      <= t3_r_d;
      t3_f_q[0]   <= n2_side[3*FW -: FW];
      t3_f_q[1]   <= n2_side[2*FW -: FW];
      t3_f_q[2]   <= n2_side[FW -: FW];
      t3_eye_q    <= n2_side[S2W-1 -: EW];
      t4_p_q      <= t4_p_d;
      t4_r_q      <= t3_r_q;
      t4_f_q      <= t3_f_q;
      t4_eye_q    <= t3_eye_q;
      t5_x_q      <= t5_x_d;
      t5_r_q      <= t4_r_q;
      t5_f_q      <= t4_f_q;
      t5_eye_q    <= t4_eye_q;
      t6_row_q    <= t6_row_d;
      t6_eye_q    <= t6_eye_d;
      t7_p_q      <= t7_p_d;
      t7_row_q    <= t6_row_q;
      t8_dot_q    <= t8_dot_d;
      t8_row_q    <= t7_row_q;
      t9_mag_q    <= t9_mag_d;
      t9_neg_q    <= {t8_dot_q[2][DW-1], t8_dot_q[1][DW-1], t8_dot_q[0][DW-1]};
      t9_row_q    <= t8_row_q;
      out_m_q     <= out_m_d;
      out_tr_q    <= out_tr_d;
    end
  end

  assign res_o.valid = out_v_q;
  assign res_o.m00   = out_m_q[0];
  assign res_o.m01   = out_m_q[1];
  assign res_o.m02   = out_m_q[2];
  assign res_o.m10   = out_m_q[3];
  assign res_o.m11   = out_m_q[4];
  assign res_o.m12   = out_m_q[5];
  assign res_o.m20   = out_m_q[6];
  assign res_o.m21   = out_m_q[7];
  assign res_o.m22   = out_m_q[8];
  assign res_o.tr_x  = $signed(out_tr_q[0]);
  assign res_o.tr_y  = $signed(out_tr_q[1]);
  assign res_o.tr_z  = $signed(out_tr_q[2]);

  // The right vector never has a y component.
  a_right_y_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.m01 == '0)
    else $error("right vector y component is not zero");

  // The right vector x component is never negative.
  a_right_x_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> !res_o.m00[XW-1])
    else $error("right vector x component is negative");

  // An accepted request shows up in the first stage.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> t0_v_q)
    else $error("accepted request was lost");

  // A stall freezes the first stage.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(t0_v_q))
    else $error("pipeline moved during a stall");

endmodule

/* tb/look_at_view_matrix_core_test.sv */
// ----------------------------------------------------------------------------
// look_at_view_matrix_core_test: self-checking bench of the view matrix core
// A queue-fed driver offers camera requests with random gaps, a monitor with
// random stalls takes the results, and each result is checked field by field
// against a fixed-point predictor of forward, right and up vectors.
// ----------------------------------------------------------------------------
module look_at_view_matrix_core_test;

  localparam int unsigned DFB     = 30;
  localparam int unsigned LATENCY = 3 * DFB + 131;

  typedef struct packed {
    logic signed [31:0] eye_x, eye_y, eye_z, aim_x, aim_y, aim_z;
  } cam_t;

  typedef struct packed {
    logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [31:0] tr_x, tr_y, tr_z;
  } view_t;

  logic clk_i;
  logic rst_ni;

  lav_in_if  req_if ();
  lav_out_if res_if ();

  look_at_view_matrix_core #(.DIR_FRAC_BITS(DFB)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .res_o (res_if.source)
  );

  cam_t  cam_q[$];
  view_t view_q[$];
  int    err_cnt;
  bit    calm;        // no idling in the last part
  bit    hold_res;    // long receiver stall
  bit    drain_wait;  // sender pauses until all results are in
  int    req_gap;
  int    res_gap;

  // Clock.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic longint unsigned umag(longint signed x);
    return x < 0 ? longint'(0) - x : x;
  endfunction

  function automatic longint unsigned sqrt_floor(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Unit vector in Q(32-DFB).DFB; returns 0 for a zero vector.
  function automatic bit unit_vec(input longint signed v[3], output longint signed o[3]);
    longint unsigned m[3];
    longint unsigned mx;
    longint unsigned len;
    longint unsigned q;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = umag(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return 1'b0;
    while (mx >= (64'd1 << 31)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < (64'd1 << 30)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    len = sqrt_floor(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << DFB) + (len >> 1)) / len;
      o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  // Minus row dot eye, rounded and saturated to 32 bits.
  function automatic logic signed [31:0] shift_of(input longint signed r[3],
                                                  input longint signed e[3]);
    longint signed   dot;
    longint unsigned m;
    longint signed   q;
    dot = r[0] * e[0] + r[1] * e[1] + r[2] * e[2];
    m = (umag(dot) + (64'd1 << (DFB - 1))) >> DFB;
    q = dot < 0 ? longint'(m) : -longint'(m);
    if (q > 64'sd2147483647) return lav_pkg::SAT_POS;
    if (q < -64'sd2147483648) return lav_pkg::SAT_NEG;
    return q[31:0];
  endfunction

  function automatic view_t view_of(cam_t c);
    longint signed one;
    longint signed e[3], d[3], f[3], r[3], u[3], t[3], nf[3];
    view_t v;
    one = 64'sd1 << DFB;
    e = '{c.eye_x, c.eye_y, c.eye_z};
    d = '{longint'(c.aim_x) - e[0], longint'(c.aim_y) - e[1], longint'(c.aim_z) - e[2]};
    if (!unit_vec(d, f)) f = '{0, 0, -one};
    // A zero forward z gives the default right vector.
    if (f[2] == 0) begin
      r = '{one, 0, 0};
    end else begin
      t = '{f[2] < 0 ? -f[2] : f[2], 0, f[2] < 0 ? f[0] : -f[0]};
      if (!unit_vec(t, r)) r = '{one, 0, 0};
    end
    t = '{r[1] * f[2] - r[2] * f[1], r[2] * f[0] - r[0] * f[2], r[0] * f[1] - r[1] * f[0]};
    if (!unit_vec(t, u)) u = '{0, one, 0};
    nf = '{-f[0], -f[1], -f[2]};
    v.m00 = r[0][31:0];  v.m01 = r[1][31:0];  v.m02 = r[2][31:0];
    v.m10 = u[0][31:0];  v.m11 = u[1][31:0];  v.m12 = u[2][31:0];
    v.m20 = nf[0][31:0]; v.m21 = nf[1][31:0]; v.m22 = nf[2][31:0];
    v.tr_x = shift_of(r, e);
    v.tr_y = shift_of(u, e);
    v.tr_z = shift_of(nf, e);
    return v;
  endfunction

  // Compares one result field and reports a mismatch.
  function automatic void chk(string name, logic signed [31:0] exp_v,
                              logic signed [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s exp %0d got %0d", name, exp_v, got_v);
      err_cnt++;
    end
  endfunction

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      3: return 32'sd0;
      default: return $signed($urandom_range(0, 1 << 24)) - (1 << 23);
    endcase
  endfunction

  // Driver: one pending request per cycle while the core is ready, random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_gap      <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        view_q.push_back(view_of({req_if.eye_x, req_if.eye_y, req_if.eye_z,
                                  req_if.aim_x, req_if.aim_y, req_if.aim_z}));
      end
      if (!req_if.valid || req_if.ready) begin
        if (req_gap > 0) begin
          req_gap      <= req_gap - 1;
          req_if.valid <= 1'b0;
        end else if (cam_q.size() > 0 && !drain_wait) begin
          cam_t c;
          c = cam_q.pop_front();
          req_if.valid <= 1'b1;
          {req_if.eye_x, req_if.eye_y, req_if.eye_z,
           req_if.aim_x, req_if.aim_y, req_if.aim_z} <= c;
          if (!calm && $urandom_range(0, 9) == 0) req_gap <= $urandom_range(1, 6);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random stalls and one long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      res_gap      <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (view_q.size() == 0) begin
          $error("unexpected result");
          err_cnt++;
        end else begin
          view_t w;
          w = view_q.pop_front();
          chk("m00", w.m00, res_if.m00);
          chk("m01", w.m01, res_if.m01);
          chk("m02", w.m02, res_if.m02);
          chk("m10", w.m10, res_if.m10);
          chk("m11", w.m11, res_if.m11);
          chk("m12", w.m12, res_if.m12);
          chk("m20", w.m20, res_if.m20);
          chk("m21", w.m21, res_if.m21);
          chk("m22", w.m22, res_if.m22);
          chk("tr_x", w.tr_x, res_if.tr_x);
          chk("tr_y", w.tr_y, res_if.tr_y);
          chk("tr_z", w.tr_z, res_if.tr_z);
        end
      end
      if (hold_res) begin
        res_if.ready <= 1'b0;
      end else if (res_gap > 0) begin
        res_gap      <= res_gap - 1;
        res_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        res_gap      <= $urandom_range(0, 5);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off, counted in its own process.
  initial begin
    hold_res = 1'b0;
    wait (rst_ni);
    repeat (400) @(posedge clk_i);
    hold_res = 1'b1;
    repeat (LATENCY + 300) @(posedge clk_i);
    hold_res = 1'b0;
  end

  // Stimulus.
  initial begin
    cam_t c;
    int   n;
    logic signed [31:0] ext[4];
    err_cnt          = 0;
    calm             = 1'b0;
    drain_wait       = 1'b0;
    ext = '{32'h7fff_ffff, 32'h8000_0000, 32'sd0, 32'sd1 <<< 16};
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni = 1'b1;

    // Directed: eye equals aim, forward z zero, straight up and down, along z, extremes.
    cam_q.push_back('{0, 0, 0, 0, 0, 0});
    cam_q.push_back('{5 << 16, -3 << 16, 7 << 16, 5 << 16, -3 << 16, 7 << 16});
    cam_q.push_back('{0, 0, 0, 1 << 16, 0, 0});
    cam_q.push_back('{0, 0, 0, 0, 1 << 16, 0});
    cam_q.push_back('{0, 0, 0, 0, -1 << 16, 0});
    cam_q.push_back('{0, 0, 0, 0, 0, -1 << 16});
    cam_q.push_back('{0, 0, 0, 0, 0, 1 << 16});
    cam_q.push_back('{1, 2, 3, 1, 2, 4});
    foreach (ext[i]) foreach (ext[j])
      cam_q.push_back('{ext[i], ext[j], ext[i], ext[j], ext[i], ext[j]});
    cam_q.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});

    for (n = 0; n < 1850; n++) begin
      c = {rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()};
      // Some cameras lie on an axis line or in a plane of the target.
      if ($urandom_range(0, 7) == 0) c.aim_z = c.eye_z;
      if ($urandom_range(0, 15) == 0) begin c.aim_x = c.eye_x; c.aim_z = c.eye_z; end
      cam_q.push_back(c);
      if (n == 900) begin
        wait (cam_q.size() == 0 && !req_if.valid);
        drain_wait = 1'b1;
        wait (view_q.size() == 0);
        @(posedge clk_i);
        drain_wait = 1'b0;
      end
      // Idling stops once most of the requests have gone out.
      if (n == 1600) begin
        wait (cam_q.size() < 200);
        calm = 1'b1;
      end
    end
    wait (cam_q.size() == 0 && !req_if.valid);
    wait (view_q.size() == 0);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (err_cnt == 0 && view_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
